### hw/rtl/rlcf_pkg.sv
// Shared types, constants and helpers of the read low-complexity filter.
package rlcf_pkg;

    localparam int CNT_W       = 11;
    localparam int BASE_W      = 8;
    localparam int PCT_W       = 7;
    localparam int LETTER_BINS = 27;
    localparam int BIN_W       = 5;
    localparam int PROD_W      = CNT_W + PCT_W;
    localparam int CFG_IDX_W   = 2;

    localparam logic [CNT_W-1:0]  CNT_MAX       = {CNT_W{1'b1}};
    localparam logic [BIN_W-1:0]  OTHER_BIN     = BIN_W'(26);
    localparam logic [BASE_W-1:0] CHAR_A        = 8'h41;
    localparam logic [BASE_W-1:0] CHAR_Z        = 8'h5A;
    localparam logic [PCT_W-1:0]  PCT_SCALE     = 7'd100;
    localparam logic [CNT_W-1:0]  MIN_LEN_RESET = 11'd35;
    localparam logic [PCT_W-1:0]  RUN_PCT_RESET = 7'd50;
    localparam logic [PCT_W-1:0]  BASE_PCT_RESET = 7'd90;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_LEN  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RUN_PCT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_PCT = 2'd2;

    typedef enum logic [1:0] {
        VERDICT_PASS  = 2'd0,
        VERDICT_SHORT = 2'd1,
        VERDICT_RUN   = 2'd2,
        VERDICT_BASE  = 2'd3
    } t_verdict;

    typedef struct packed {
        logic [BASE_W-1:0] base;
        logic [CNT_W-1:0]  clip_head;
        logic [CNT_W-1:0]  clip_tail;
        logic              last;
    } t_in_item;

    typedef struct packed {
        logic [1:0]       verdict;
        logic [CNT_W-1:0] longest_run_out;
        logic [CNT_W-1:0] top_count_out;
    } t_out_item;

    typedef struct packed {
        logic [CFG_IDX_W-1:0] index;
        logic [CNT_W-1:0]     data;
    } t_cfg_item;

    // Totals of one finished read, handed to the verdict stage.
    typedef struct packed {
        logic [CNT_W-1:0] run_best;
        logic [CNT_W-1:0] count_best;
        logic [CNT_W-1:0] length;
        logic             short_reject;
    } t_fin;

    // Uppercase letters get their own bin; every other byte shares the last one.
    function automatic logic [BIN_W-1:0] bin_of(input logic [BASE_W-1:0] b);
        logic [BASE_W-1:0] diff;
        diff = b - CHAR_A;
        if (b >= CHAR_A && b <= CHAR_Z) begin
            return diff[BIN_W-1:0];
        end
        return OTHER_BIN;
    endfunction

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (v == CNT_MAX) ? v : v + CNT_W'(1);
    endfunction

endpackage

### hw/rtl/rlcf_in_if.sv
// Channel interfaces for bases in, verdicts out and configuration writes.
interface rlcf_in_if;
    import rlcf_pkg::*;
    logic     valid;
    logic     ready;
    t_in_item item;
    modport source (output valid, output item, input ready);
    modport sink (input valid, input item, output ready);
endinterface

interface rlcf_out_if;
    import rlcf_pkg::*;
    logic      valid;
    logic      ready;
    t_out_item item;
    modport source (output valid, output item, input ready);
    modport sink (input valid, input item, output ready);
endinterface

interface rlcf_cfg_if;
    import rlcf_pkg::*;
    logic      valid;
    logic      ready;
    t_cfg_item item;
    modport source (output valid, output item, input ready);
    modport sink (input valid, input item, output ready);
endinterface

### hw/rtl/rlcf_verdict.sv
// Verdict stage: percent checks on a finished read and the result register.
module rlcf_verdict (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_fin_valid,
    input  rlcf_pkg::t_fin            i_fin,
    input  logic [rlcf_pkg::PCT_W-1:0] i_run_pct,
    input  logic [rlcf_pkg::PCT_W-1:0] i_base_pct,
    output logic                      o_fin_take,
    rlcf_out_if.source                o_res
);
    import rlcf_pkg::*;

    logic              r_out_valid;
    t_out_item         r_out;
    logic [PROD_W-1:0] run_scaled;
    logic [PROD_W-1:0] run_limit;
    logic [PROD_W-1:0] base_scaled;
    logic [PROD_W-1:0] base_limit;
    t_verdict          verdict;

    assign o_fin_take = !r_out_valid || o_res.ready;

    // Checks compare value*100 against pct*length, exactly.
    always_comb begin
        run_scaled  = PROD_W'(i_fin.run_best) * PROD_W'(PCT_SCALE);
        run_limit   = PROD_W'(i_run_pct) * PROD_W'(i_fin.length);
        base_scaled = PROD_W'(i_fin.count_best) * PROD_W'(PCT_SCALE);
        base_limit  = PROD_W'(i_base_pct) * PROD_W'(i_fin.length);
        if (i_fin.short_reject) begin
            verdict = VERDICT_SHORT;
        end else if (run_scaled > run_limit) begin
            verdict = VERDICT_RUN;
        end else if (base_scaled > base_limit) begin
            verdict = VERDICT_BASE;
        end else begin
            verdict = VERDICT_PASS;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_fin_take) begin
            r_out_valid <= i_fin_valid;
        end
        if (o_fin_take && i_fin_valid) begin
            r_out.verdict         <= verdict;
            r_out.longest_run_out <= i_fin.run_best;
            r_out.top_count_out   <= i_fin.count_best;
        end
    end

    assign o_res.valid = r_out_valid;
    assign o_res.item  = r_out;

endmodule

### hw/rtl/read_low_complexity_filter.sv
// A read's totals are registered in a totals stage, then its verdict in the result register.
// One base per cycle while the totals stage can take a read; the per-letter counters and run
// tracker track each accepted base. A read's totals wait in a one-entry stage, so the
// next read's bases flow while a result waits, up to its last base. Config port always ready.
// Reset: counters and run state cleared, no result pending, limits at 35, 50 and 90.
module read_low_complexity_filter (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rlcf_in_if.sink     i_in,
    rlcf_cfg_if.sink    i_cfg,
    rlcf_out_if.source  o_res
);
    import rlcf_pkg::*;

    logic [CNT_W-1:0]  r_counts [LETTER_BINS];
    logic [BASE_W-1:0] r_prev;
    logic [CNT_W-1:0]  r_run_now;
    logic [CNT_W-1:0]  r_run_best;
    logic [CNT_W-1:0]  r_count_best;
    logic [CNT_W-1:0]  r_seen;
    logic [CNT_W-1:0]  r_min_len;
    logic [PCT_W-1:0]  r_run_pct;
    logic [PCT_W-1:0]  r_base_pct;
    logic              r_fin_valid;
    t_fin              r_fin;

    logic [BIN_W-1:0]  bin;
    logic [CNT_W-1:0]  n_count;
    logic [CNT_W-1:0]  n_count_best;
    logic [CNT_W-1:0]  n_run_now;
    logic [CNT_W-1:0]  n_run_best;
    logic [CNT_W-1:0]  n_seen;
    logic              fin_take;
    logic              accept;
    logic              both_clipped;

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = !r_fin_valid || fin_take;
    assign accept      = i_in.valid && i_in.ready;

    always_comb begin
        bin          = bin_of(i_in.item.base);
        n_count      = sat_inc(r_counts[bin]);
        n_count_best = (n_count > r_count_best) ? n_count : r_count_best;
        // The first base of a read always opens a new run.
        if (r_seen == '0 || i_in.item.base != r_prev) begin
            n_run_now = CNT_W'(1);
        end else begin
            n_run_now = sat_inc(r_run_now);
        end
        n_run_best   = (n_run_now > r_run_best) ? n_run_now : r_run_best;
        n_seen       = sat_inc(r_seen);
        both_clipped = (|i_in.item.clip_head[CNT_W-1:1]) && (|i_in.item.clip_tail[CNT_W-1:1]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < LETTER_BINS; i++) begin
                r_counts[i] <= '0;
            end
            r_prev       <= '0;
            r_run_now    <= '0;
            r_run_best   <= '0;
            r_count_best <= '0;
            r_seen       <= '0;
            r_min_len    <= MIN_LEN_RESET;
            r_run_pct    <= RUN_PCT_RESET;
            r_base_pct   <= BASE_PCT_RESET;
            r_fin_valid  <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                case (i_cfg.item.index)
                    CFG_MIN_LEN:  r_min_len  <= i_cfg.item.data;
                    CFG_RUN_PCT:  r_run_pct  <= i_cfg.item.data[PCT_W-1:0];
                    CFG_BASE_PCT: r_base_pct <= i_cfg.item.data[PCT_W-1:0];
                    default: ;
                endcase
            end

            // The stage empties when the verdict stage takes it and refills on a last base.
            r_fin_valid <= (r_fin_valid && !fin_take) || (accept && i_in.item.last);

            if (accept) begin
                if (i_in.item.last) begin
                    // Read finished: hand over the totals and start the next read clean.
                    for (int i = 0; i < LETTER_BINS; i++) begin
                        r_counts[i] <= '0;
                    end
                    r_prev       <= '0;
                    r_run_now    <= '0;
                    r_run_best   <= '0;
                    r_count_best <= '0;
                    r_seen       <= '0;
                end else begin
                    r_counts[bin] <= n_count;
                    r_prev        <= i_in.item.base;
                    r_run_now     <= n_run_now;
                    r_run_best    <= n_run_best;
                    r_count_best  <= n_count_best;
                    r_seen        <= n_seen;
                end
            end
        end

        if (accept && i_in.item.last) begin
            r_fin.run_best     <= n_run_best;
            r_fin.count_best   <= n_count_best;
            r_fin.length       <= n_seen;
            r_fin.short_reject <= both_clipped && (n_seen < r_min_len);
        end
    end

    rlcf_verdict u_verdict (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_fin_valid(r_fin_valid),
        .i_fin      (r_fin),
        .i_run_pct  (r_run_pct),
        .i_base_pct (r_base_pct),
        .o_fin_take (fin_take),
        .o_res      (o_res)
    );

endmodule
